// ----- hdl/fwwa_pkg.sv -----
// Package for the flash write word aligner.
// Holds the word entry type, field widths and the register map constants.
// No dependencies; every other file of the block refers to it by scoped names.
package fwwa_pkg;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned WordW     = 64;
  localparam int unsigned LaneCount = 8;
  localparam int unsigned LaneIdxW  = 3;
  localparam int unsigned Log2W     = 2;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  // Erased flash reads as all ones
  localparam logic [WordW-1:0] ErasedWord = {WordW{1'b1}};

  // Register map (word index taken from paddr[2])
  localparam logic RegWordSizeLog2 = 1'b0;
  localparam logic [Log2W-1:0] WordSizeLog2Reset = 2'd2;

  // Word queue depth and pointer width
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // One aligned word handed from the packer to the output queue
  typedef struct packed {
    logic [AddrW-1:0] word_address;
    logic [WordW-1:0] word_data;
    logic             last_word;
  } word_entry_t;

endpackage

// ----- hdl/fwwa_if.sv -----
// Channel interfaces for the flash write word aligner.
// Byte channel into the block and word channel out of it, valid/ready handshake.
// Depends on fwwa_pkg for field widths.
interface fwwa_byte_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  data_byte;
  logic [fwwa_pkg::AddrW-1:0]  start_address;
  logic                        first_byte;
  logic                        last_byte;

  modport source (output valid, data_byte, start_address, first_byte, last_byte,
                  input ready);
  modport sink (input valid, data_byte, start_address, first_byte, last_byte,
                output ready);
endinterface

interface fwwa_word_if;
  logic                        valid;
  logic                        ready;
  logic [fwwa_pkg::AddrW-1:0]  word_address;
  logic [fwwa_pkg::WordW-1:0]  word_data;
  logic                        last_word;

  modport source (output valid, word_address, word_data, last_word, input ready);
  modport sink (input valid, word_address, word_data, last_word, output ready);
endinterface

// ----- hdl/fwwa_front.sv -----
// Front part of the flash write word aligner: takes bytes, packs them into
// the word being assembled and decides when a word is complete.
// Depends on fwwa_pkg for widths and the word entry type.
module fwwa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fwwa_pkg::Log2W-1:0]    word_lg_i,
  input  logic                          byte_valid_i,
  input  logic [7:0]                    data_byte_i,
  input  logic [fwwa_pkg::AddrW-1:0]    start_address_i,
  input  logic                          first_byte_i,
  input  logic                          last_byte_i,
  output logic                          byte_ready_o,
  output logic                          push_o,
  output fwwa_pkg::word_entry_t         push_entry_o,
  input  logic                          queue_full_i
);

  logic [fwwa_pkg::WordW-1:0]    buf_q, buf_d;
  logic [fwwa_pkg::LaneIdxW-1:0] pos_q, pos_d;
  logic [fwwa_pkg::AddrW-1:0]    addr_q, addr_d;

  logic [3:0]                    word_bytes;
  logic [3:0]                    byte_mask;
  logic [fwwa_pkg::LaneIdxW-1:0] lane_mask;
  logic [fwwa_pkg::LaneIdxW-1:0] lane;
  logic [fwwa_pkg::WordW-1:0]    base_buf;
  logic [fwwa_pkg::WordW-1:0]    new_buf;
  logic [fwwa_pkg::LaneIdxW-1:0] base_pos;
  logic [fwwa_pkg::AddrW-1:0]    base_addr;
  logic                          accept;
  logic                          word_done;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  // Word size in bytes and the lane mask that follows from it
  assign word_bytes = 4'(1) << word_lg_i;
  assign byte_mask  = word_bytes - 4'(1);
  assign lane_mask  = byte_mask[fwwa_pkg::LaneIdxW-1:0];

  // Start of a write: realign the address, erase the buffer, skip to the offset
  always_comb begin
    if (first_byte_i) begin
      base_addr = start_address_i &
                  ~{{(fwwa_pkg::AddrW-fwwa_pkg::LaneIdxW){1'b0}}, lane_mask};
      base_buf  = fwwa_pkg::ErasedWord;
      base_pos  = start_address_i[fwwa_pkg::LaneIdxW-1:0] & lane_mask;
    end else begin
      base_addr = addr_q;
      base_buf  = buf_q;
      base_pos  = pos_q;
    end
  end

  assign lane = base_pos & lane_mask;

  // Drop the byte into its lane
  always_comb begin
    new_buf = base_buf;
    for (int i = 0; i < fwwa_pkg::LaneCount; i++) begin
      if (lane == fwwa_pkg::LaneIdxW'(i)) begin
        new_buf[i*8 +: 8] = data_byte_i;
      end
    end
  end

  // Word closes on its top lane or on the last byte of the write
  assign word_done = (lane == lane_mask) || last_byte_i;

  assign push_o                    = accept && word_done;
  assign push_entry_o.word_address = base_addr;
  assign push_entry_o.word_data    = new_buf;
  assign push_entry_o.last_word    = last_byte_i;

  // Advance the packing state
  always_comb begin
    buf_d  = buf_q;
    pos_d  = pos_q;
    addr_d = addr_q;
    if (accept) begin
      if (word_done) begin
        buf_d  = fwwa_pkg::ErasedWord;
        pos_d  = '0;
        addr_d = base_addr + {{(fwwa_pkg::AddrW-4){1'b0}}, word_bytes};
      end else begin
        buf_d  = new_buf;
        pos_d  = lane + fwwa_pkg::LaneIdxW'(1);
        addr_d = base_addr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= fwwa_pkg::ErasedWord;
      pos_q  <= '0;
      addr_q <= '0;
    end else begin
      buf_q  <= buf_d;
      pos_q  <= pos_d;
      addr_q <= addr_d;
    end
  end

endmodule

// ----- hdl/fwwa_queue.sv -----
// Back part of the flash write word aligner: a two-entry word queue that
// presents finished words on the output channel from registers.
// Depends on fwwa_pkg for the word entry type and queue sizing.
module fwwa_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  fwwa_pkg::word_entry_t   push_entry_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output fwwa_pkg::word_entry_t   out_entry_o
);

  fwwa_pkg::word_entry_t             mem_q [fwwa_pkg::QueueDepth];
  logic [fwwa_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [fwwa_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [fwwa_pkg::QueueCntW-1:0]    count_q, count_d;
  logic                              pop;

  assign full_o      = (count_q == fwwa_pkg::QueueCntW'(fwwa_pkg::QueueDepth));
  assign out_valid_o = (count_q != '0);
  assign out_entry_o = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Move pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + fwwa_pkg::QueuePtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + fwwa_pkg::QueuePtrW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + fwwa_pkg::QueueCntW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - fwwa_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- hdl/flash_write_word_aligner.sv -----
// Flash write word aligner: packs a byte stream into aligned flash words.
// Throughput: one byte per cycle while the word queue is not full; one word out per cycle at most.
// A closed word is registered into the queue; if the queue was empty, it is valid on the output in the cycle after.
// A two-entry word queue parts the byte packer from the output handshake.
// Reset (rst_ni low, asynchronous): queue empty, buffer erased to 0xFF,
// lane 0 at address 0, word size register back to 4 bytes.
module flash_write_word_aligner #(
  parameter int unsigned MAX_WORD_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwwa_pkg::PaddrW-1:0]   paddr,
  input  logic [fwwa_pkg::PdataW-1:0]   pwdata,
  output logic [fwwa_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  fwwa_byte_if.sink                     in_ch,
  fwwa_word_if.source                   out_ch
);

  localparam logic [fwwa_pkg::Log2W-1:0] MaxLog2 =
    (MAX_WORD_BYTES >= 8) ? 2'd3 :
    (MAX_WORD_BYTES >= 4) ? 2'd2 :
    (MAX_WORD_BYTES >= 2) ? 2'd1 : 2'd0;

  logic [fwwa_pkg::Log2W-1:0] word_lg_q, word_lg_d;
  logic [fwwa_pkg::Log2W-1:0] word_lg_eff;
  logic                       reg_write;
  logic                       push;
  logic                       queue_full;
  fwwa_pkg::word_entry_t      push_entry;
  fwwa_pkg::word_entry_t      out_entry;

  // Configuration register write and read back
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == fwwa_pkg::RegWordSizeLog2);

  always_comb begin
    word_lg_d = word_lg_q;
    if (reg_write) begin
      word_lg_d = pwdata[fwwa_pkg::Log2W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_lg_q <= fwwa_pkg::WordSizeLog2Reset;
    end else begin
      word_lg_q <= word_lg_d;
    end
  end

  assign prdata = (paddr[2] == fwwa_pkg::RegWordSizeLog2) ?
                  {{(fwwa_pkg::PdataW-fwwa_pkg::Log2W){1'b0}}, word_lg_q} : '0;

  // Clamp the word size to what the flash supports
  assign word_lg_eff = (word_lg_q > MaxLog2) ? MaxLog2 : word_lg_q;

  fwwa_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .word_lg_i       (word_lg_eff),
    .byte_valid_i    (in_ch.valid),
    .data_byte_i     (in_ch.data_byte),
    .start_address_i (in_ch.start_address),
    .first_byte_i    (in_ch.first_byte),
    .last_byte_i     (in_ch.last_byte),
    .byte_ready_o    (in_ch.ready),
    .push_o          (push),
    .push_entry_o    (push_entry),
    .queue_full_i    (queue_full)
  );

  fwwa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (queue_full),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_entry_o  (out_entry)
  );

  assign out_ch.word_address = out_entry.word_address;
  assign out_ch.word_data    = out_entry.word_data;
  assign out_ch.last_word    = out_entry.last_word;

endmodule

// ----- hdl/fwwa_checker.sv -----
// Port-level checks for the flash write word aligner.
// Watches both channels of the top level; bound to it at the end of this file.
// Depends on fwwa_pkg for field widths.
module fwwa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_last_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [fwwa_pkg::AddrW-1:0]   out_address_i,
  input logic [fwwa_pkg::WordW-1:0]   out_data_i,
  input logic                         out_last_i
);

  // Hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_address_i) && $stable(out_data_i) && $stable(out_last_i))
    else $error("stalled output word changed");

  // The last byte of a write always closes a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("no word after the last byte of a write");

  // Input back-pressure only comes from words waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no word pending");

endmodule

bind flash_write_word_aligner fwwa_checker u_fwwa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .in_last_i     (in_ch.last_byte),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_address_i (out_ch.word_address),
  .out_data_i    (out_ch.word_data),
  .out_last_i    (out_ch.last_word)
);
